[rtl/swpi_pkg.sv]
package swpi_pkg;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_INS_AT  = 2'd2,
    OP_INS_BTW = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned FillW = 8;

  typedef logic signed [WordW-1:0] word_t;

endpackage

[rtl/stack_with_positional_insert.sv]
// Channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------------
// in       | input     | in_valid_i/in_stall_o  | op_i, value_i, position_i, first_value_i,
//          |           |                        | second_value_i
// out      | output    | out_valid_o/out_stall_i| status_o, popped_value_o, fill_count_o
//
// One word is worked on at a time; all entries live in a single-port-write, one-read memory.
// Insert at position moves the entries from position upward up by one, or appends on top when
// position equals the count; insert between pair searches upward from the bottom entry.
// The memory's one read port and one write port bound the rate: at most one entry is read and one written per cycle.
// Reset empties the stack at once; the memory itself is never cleared.
// A new word is taken while the previous result still waits; the last step of the next
// word holds until the output register is free.
module stack_with_positional_insert #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  swpi_pkg::op_e          op_i,
  input  swpi_pkg::word_t        value_i,
  input  logic [7:0]             position_i,
  input  swpi_pkg::word_t        first_value_i,
  input  swpi_pkg::word_t        second_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output swpi_pkg::status_e      status_o,
  output swpi_pkg::word_t        popped_value_o,
  output logic [7:0]             fill_count_o
);
  import swpi_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;

  function automatic logic [FillW-1:0] fill_of(input logic [CW-1:0] c);
    logic [CmpW-1:0] ext;
    ext = CmpW'(c);
    return ext[FillW-1:0];
  endfunction

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   ra_q, ra_d;
  logic            pend_q, pend_d;
  word_t           prev_q, prev_d;

  op_e             op_q;
  word_t           value_q, first_q, second_q;
  logic [PosW-1:0] position_q;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  word_t           popped_q, popped_d;
  logic [FillW-1:0] fill_q, fill_d;

  word_t           mem_q [DEPTH];
  word_t           rdata_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  word_t           mem_wdata;

  logic            in_accept;
  logic            slot_free;
  logic            full;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic [CW-1:0]   cnt_inc, cnt_dec, idx_inc, idx_dec, j_idx;
  logic            hit;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign full       = (cnt_q == Full);
  assign pos_ext    = CmpW'(position_q);
  assign cnt_ext    = CmpW'(cnt_q);
  assign cnt_inc    = cnt_q + 1'b1;
  assign cnt_dec    = cnt_q - 1'b1;
  assign idx_inc    = idx_q + 1'b1;
  assign idx_dec    = idx_q - 1'b1;
  assign j_idx      = ra_q - 1'b1;
  // The pair ends at the entry just read; the lower word sits in prev_q.
  assign hit = (j_idx != '0) && (prev_q == first_q) && (rdata_q == second_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    ra_d        = ra_q;
    pend_d      = pend_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    popped_d    = popped_q;
    fill_d      = fill_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = value_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_PUSH: begin
            if (slot_free) begin
              out_valid_d = 1'b1;
              popped_d    = '0;
              state_d     = S_IDLE;
              if (full) begin
                status_d = ST_OVERFLOW;
                fill_d   = fill_of(cnt_q);
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_q);
                cnt_d     = cnt_inc;
                status_d  = ST_OK;
                fill_d    = fill_of(cnt_inc);
              end
            end
          end
          OP_POP: begin
            if (cnt_q == '0) begin
              if (slot_free) begin
                out_valid_d = 1'b1;
                popped_d    = '0;
                status_d    = ST_UNDERFLOW;
                fill_d      = fill_of(cnt_q);
                state_d     = S_IDLE;
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cnt_dec);
              state_d   = S_POP;
            end
          end
          OP_INS_AT: begin
            if (full || (pos_ext > cnt_ext)) begin
              if (slot_free) begin
                out_valid_d = 1'b1;
                popped_d    = '0;
                status_d    = ST_BADPOS;
                fill_d      = fill_of(cnt_q);
                state_d     = S_IDLE;
              end
            end else begin
              pos_d   = pos_ext[CW-1:0];
              idx_d   = cnt_q;
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          default: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            ra_d      = CW'(1);
            state_d   = S_SEARCH;
          end
        endcase
      end
      S_POP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          popped_d    = rdata_q;
          status_d    = ST_OK;
          cnt_d       = cnt_dec;
          fill_d      = fill_of(cnt_dec);
          state_d     = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (full) begin
            if (slot_free) begin
              out_valid_d = 1'b1;
              popped_d    = '0;
              status_d    = ST_BADPOS;
              fill_d      = fill_of(cnt_q);
              state_d     = S_IDLE;
            end
          end else begin
            pos_d   = j_idx;
            idx_d   = cnt_q;
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end else if (ra_q >= cnt_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            popped_d    = '0;
            status_d    = ST_NOTFOUND;
            fill_d      = fill_of(cnt_q);
            state_d     = S_IDLE;
          end
        end else begin
          prev_d    = rdata_q;
          mem_re    = 1'b1;
          mem_raddr = AW'(ra_q);
          ra_d      = ra_q + 1'b1;
        end
      end
      S_SHIFT: begin
        // Reads walk down from the top while each write lands one entry above its read, in the
        // cycle after that read, so the two never touch the same entry.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_inc);
          mem_wdata = rdata_q;
        end
        if (idx_q != pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_dec);
          idx_d     = idx_dec;
          pend_d    = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else if (slot_free) begin
          mem_we      = 1'b1;
          mem_waddr   = AW'(pos_q);
          mem_wdata   = value_q;
          cnt_d       = cnt_inc;
          out_valid_d = 1'b1;
          popped_d    = '0;
          status_d    = ST_OK;
          fill_d      = fill_of(cnt_inc);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      ra_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      ra_q        <= ra_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= op_i;
      value_q    <= value_i;
      position_q <= position_i;
      first_q    <= first_value_i;
      second_q   <= second_value_i;
    end
    prev_q   <= prev_d;
    status_q <= status_d;
    popped_q <= popped_d;
    fill_q   <= fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign fill_count_o   = fill_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("entry count above depth");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (idx_q >= pos_q) && (idx_q <= cnt_q))
    else $error("shift index out of range");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_OVERFLOW)) |-> (fill_q == fill_of(Full)))
    else $error("overflow reported on a stack that is not full");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $rose(out_valid_q) || $past(out_valid_q && !out_stall_i))
    else $error("entry count changed without a result");

endmodule

[tb/stack_with_positional_insert_tb.sv]
module stack_with_positional_insert_tb;
  import swpi_pkg::*;

  localparam int unsigned Depth = 128;
  localparam int unsigned RandomWords = 1030;
  localparam int unsigned CalmWords = 250;
  localparam int unsigned DrainCycles = 300;
  // Two copies of the stack: one tracks what has been planned, the other what was accepted.
  localparam int PlanView = 0;
  localparam int BusView = 1;

  typedef struct {
    op_e        op;
    word_t      value;
    logic [7:0] position;
    word_t      first_value;
    word_t      second_value;
  } stack_cmd_t;

  typedef struct {
    status_e    status;
    word_t      popped_value;
    logic [7:0] fill_count;
  } stack_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  op_e        op_i = OP_PUSH;
  word_t      value_i = '0;
  logic [7:0] position_i = '0;
  word_t      first_value_i = '0;
  word_t      second_value_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  status_e    status_o;
  word_t      popped_value_o;
  logic [7:0] fill_count_o;

  word_t       stack_mem [2][Depth];
  int unsigned stack_cnt [2];

  stack_cmd_t  cmd_queue[$];
  stack_res_t  awaited_results[$];
  stack_cmd_t  cmd_on_bus;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned calm_after = 32'hFFFF_FFFF;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned fail_cnt = 0;

  stack_with_positional_insert #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .first_value_i (first_value_i),
    .second_value_i(second_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .fill_count_o  (fill_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic status_e place_word(int sel, word_t w, int unsigned pos);
    int unsigned i;
    if (stack_cnt[sel] >= Depth || pos > stack_cnt[sel]) return ST_BADPOS;
    for (i = stack_cnt[sel]; i > pos; i--) stack_mem[sel][i] = stack_mem[sel][i-1];
    stack_mem[sel][pos] = w;
    stack_cnt[sel]++;
    return ST_OK;
  endfunction

  function automatic stack_res_t stack_apply(int sel, stack_cmd_t c);
    stack_res_t r;
    int         hit;
    r.status = ST_OK;
    r.popped_value = '0;
    hit = -1;
    case (c.op)
      OP_PUSH: begin
        if (stack_cnt[sel] >= Depth) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_mem[sel][stack_cnt[sel]] = c.value;
          stack_cnt[sel]++;
        end
      end
      OP_POP: begin
        if (stack_cnt[sel] == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          stack_cnt[sel]--;
          r.popped_value = stack_mem[sel][stack_cnt[sel]];
        end
      end
      OP_INS_AT: r.status = place_word(sel, c.value, int'(c.position));
      default: begin
        // The lowest matching pair wins.
        for (int i = 0; i + 1 < int'(stack_cnt[sel]); i++) begin
          if (hit < 0 && stack_mem[sel][i] == c.first_value &&
              stack_mem[sel][i+1] == c.second_value) hit = i;
        end
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.status = place_word(sel, c.value, hit + 1);
      end
    endcase
    r.fill_count = 8'(stack_cnt[sel]);
    return r;
  endfunction

  task automatic plan_cmd(op_e op, word_t value, logic [7:0] pos, word_t lo, word_t hi);
    stack_cmd_t c;
    c.op = op;
    c.value = value;
    c.position = pos;
    c.first_value = lo;
    c.second_value = hi;
    void'(stack_apply(PlanView, c));
    cmd_queue.push_back(c);
  endtask

  // A small pool of values makes repeated adjacent pairs likely.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return word_t'(0);
      1: return word_t'(-1);
      2: return word_t'(1);
      3: return word_t'(32'h8000_0000);
      4: return word_t'(32'h7FFF_FFFF);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic plan_random(bit grow);
    int unsigned r;
    int unsigned cnt;
    int unsigned j;
    op_e         op;
    logic [7:0]  pos;
    word_t       lo;
    word_t       hi;
    cnt = stack_cnt[PlanView];
    r = $urandom_range(0, 99);
    if (grow) op = (r < 35) ? OP_PUSH : (r < 45) ? OP_POP : (r < 75) ? OP_INS_AT : OP_INS_BTW;
    else op = (r < 10) ? OP_PUSH : (r < 70) ? OP_POP : (r < 85) ? OP_INS_AT : OP_INS_BTW;
    r = $urandom_range(0, 99);
    if (r < 70) pos = 8'($urandom_range(0, cnt));
    else if (r < 90) pos = 8'($urandom_range(0, 255));
    else pos = 8'(cnt + 1);
    if (cnt >= 2 && $urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, cnt - 2);
      lo = stack_mem[PlanView][j];
      hi = stack_mem[PlanView][j+1];
    end else begin
      lo = pick_word();
      hi = pick_word();
    end
    plan_cmd(op, pick_word(), pos, lo, hi);
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Word driver: a stalled word is held, otherwise the next one goes out after any gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(stack_apply(BusView, cmd_on_bus));
        sent_cnt++;
      end
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() != 0 && sent_cnt < calm_after &&
                   $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        cmd_on_bus = cmd_queue.pop_front();
        in_valid_i <= 1'b1;
        op_i <= cmd_on_bus.op;
        value_i <= cmd_on_bus.value;
        position_i <= cmd_on_bus.position;
        first_value_i <= cmd_on_bus.first_value;
        second_value_i <= cmd_on_bus.second_value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor with random stall bursts on the output side.
  always @(posedge clk_i) begin
    stack_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_cnt++;
        if (awaited_results.size() == 0) begin
          $error("result word with none expected: status %0d fill %0d", status_o, fill_count_o);
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_cnt++;
          end
          if (popped_value_o !== want.popped_value) begin
            $error("popped_value: expected %0d, actual %0d", want.popped_value, popped_value_o);
            fail_cnt++;
          end
          if (fill_count_o !== want.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count, fill_count_o);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (got_cnt < calm_after && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    bit          grow;
    int unsigned edge_hits;
    stack_cnt[PlanView] = 0;
    stack_cnt[BusView] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty-stack cases, appending through insert-at, pair search and its misses.
    plan_cmd(OP_POP, 0, 8'd0, 0, 0);
    plan_cmd(OP_INS_BTW, 5, 8'd0, 0, 0);
    plan_cmd(OP_INS_AT, 9, 8'd1, 0, 0);
    plan_cmd(OP_INS_AT, 32'h7FFF_FFFF, 8'd0, 0, 0);
    plan_cmd(OP_INS_BTW, 3, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    plan_cmd(OP_PUSH, 32'h8000_0000, 8'd0, 0, 0);
    plan_cmd(OP_PUSH, -1, 8'd0, 0, 0);
    plan_cmd(OP_PUSH, 0, 8'd0, 0, 0);
    plan_cmd(OP_INS_AT, 1, 8'd0, 0, 0);
    plan_cmd(OP_INS_AT, 7, 8'd255, 0, 0);
    plan_cmd(OP_INS_AT, 32'h5555_5555, 8'd5, 0, 0);
    plan_cmd(OP_INS_BTW, 32'hAAAA_AAAA, 8'd0, 32'h8000_0000, -1);
    plan_cmd(OP_INS_BTW, 4, 8'd0, -1, -1);
    plan_cmd(OP_INS_BTW, 2, 8'd0, 1, 32'h7FFF_FFFF);
    plan_cmd(OP_INS_AT, 32'h1234_5678, 8'd3, 0, 0);
    plan_cmd(OP_INS_AT, -2, 8'd6, 0, 0);
    plan_cmd(OP_POP, 0, 8'd0, 0, 0);
    plan_cmd(OP_POP, 0, 8'd0, 0, 0);
    plan_cmd(OP_POP, 0, 8'd0, 0, 0);
    wait_idle();

    // Random part swings the stack between empty and full, lingering at both ends.
    grow = 1'b1;
    edge_hits = 0;
    for (int n = 0; n < RandomWords; n++) begin
      if (grow && stack_cnt[PlanView] == Depth) begin
        edge_hits++;
        if (edge_hits > 12) begin
          grow = 1'b0;
          edge_hits = 0;
        end
      end else if (!grow && stack_cnt[PlanView] == 0) begin
        edge_hits++;
        if (edge_hits > 4) begin
          grow = 1'b1;
          edge_hits = 0;
        end
      end else if ($urandom_range(0, 99) == 0) begin
        grow = !grow;
      end
      plan_random(grow);
    end
    calm_after = sent_cnt + RandomWords - CalmWords;
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

[stack_with_positional_insert.f]
rtl/swpi_pkg.sv
rtl/stack_with_positional_insert.sv
tb/stack_with_positional_insert_tb.sv
